// ===== rtl/pbcs_pkg.sv =====
`default_nettype none

package pbcs_pkg;

    // transaction kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_APM   = 2'd2;

    // function numbers
    localparam logic [2:0] FUNC_BRIDGE = 3'd0;
    localparam logic [2:0] FUNC_IDE    = 3'd1;

    // configuration space geometry
    localparam int CFG_DEPTH = 512;
    localparam int CFG_AW    = 9;

    // byte offsets used by more than one file
    localparam logic [7:0] ADDR_CMD     = 8'h04;
    localparam logic [7:0] ADDR_STATUS  = 8'h07;
    localparam logic [7:0] ADDR_BM_LO   = 8'h20;
    localparam logic [7:0] ADDR_BM_HI   = 8'h21;
    localparam logic [7:0] ADDR_IDE_PRI = 8'h41;
    localparam logic [7:0] ADDR_IDE_SEC = 8'h43;
    localparam logic [7:0] ADDR_DMA     = 8'h4c;
    localparam logic [7:0] ADDR_ISA     = 8'h6a;
    localparam logic [7:0] ADDR_SMI_EN  = 8'ha2;
    localparam logic [7:0] ADDR_SMI_STS = 8'haa;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] func;
        logic [7:0] addr;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        smi_pulse;
        logic        route_valid;
        logic [2:0]  route_line;
        logic [3:0]  route_irq;
        logic        dma_alias_on;
        logic [2:0]  isa_divisor;
        logic        ide_primary_on;
        logic        ide_secondary_on;
        logic        bus_master_on;
        logic [15:0] bus_master_base;
    } result_t;

    // per-transaction event fields
    typedef struct packed {
        logic [7:0] rd;
        logic       smi;
        logic       rv;
        logic [2:0] rl;
        logic [3:0] ri;
    } event_t;

    // write-back decision from the update logic
    typedef struct packed {
        logic       we;
        logic [7:0] wbyte;
        event_t     ev;
    } upd_t;

    // reset image, function 1 lives at offset 256
    function automatic logic [7:0] reset_byte(input logic [CFG_AW-1:0] a);
        logic [7:0] b;
        b = 8'h00;
        unique case (a)
            9'h000: b = 8'h86;
            9'h001: b = 8'h80;
            9'h002: b = 8'h2e;
            9'h003: b = 8'h12;
            9'h004: b = 8'h07;
            9'h007: b = 8'h02;
            9'h008: b = 8'h02;
            9'h00a: b = 8'h01;
            9'h00b: b = 8'h06;
            9'h00e: b = 8'h80;
            9'h04c: b = 8'h4d;
            9'h04e: b = 8'h03;
            9'h060: b = 8'h80;
            9'h061: b = 8'h80;
            9'h062: b = 8'h80;
            9'h063: b = 8'h80;
            9'h069: b = 8'h02;
            9'h070: b = 8'h80;
            9'h071: b = 8'h80;
            9'h076: b = 8'h0c;
            9'h077: b = 8'h0c;
            9'h0a0: b = 8'h08;
            9'h0a8: b = 8'h0f;
            9'h100: b = 8'h86;
            9'h101: b = 8'h80;
            9'h102: b = 8'h30;
            9'h103: b = 8'h12;
            9'h106: b = 8'h80;
            9'h107: b = 8'h02;
            9'h108: b = 8'h02;
            9'h109: b = 8'h80;
            9'h10a: b = 8'h01;
            9'h10b: b = 8'h01;
            9'h120: b = 8'h01;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // irq number from a routing byte, 0 when disabled or not routable
    function automatic logic [3:0] irq_of(input logic [7:0] b);
        logic [3:0] v;
        logic       ok;
        v  = b[3:0];
        ok = ((v >= 4'd3) && (v <= 4'd7)) || ((v >= 4'd9) && (v <= 4'd12))
             || (v >= 4'd14);
        return (b[7] && ok) ? v : 4'd0;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pbcs_ram.sv =====
`default_nettype none

module pbcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/pbcs_update.sv =====
`default_nettype none

module pbcs_update
    import pbcs_pkg::*;
(
    input  wire item_t      item,
    input  wire logic [7:0] old_byte,
    input  wire logic       smi_en,
    output upd_t            upd
);

    logic [7:0] v;

    assign v = item.data;

    // per-address write rules and event fields
    always_comb
    begin
        upd = '0;
        unique case (item.kind)
            KIND_WRITE:
            begin
                if (item.func == FUNC_BRIDGE)
                begin
                    upd.we = 1'b1;
                    unique case (item.addr)
                        ADDR_CMD:    upd.wbyte = (v & 8'h08) | 8'h07;
                        ADDR_STATUS: upd.wbyte = old_byte & ~(v & 8'h38);
                        8'h4e:       upd.wbyte = v & 8'hf7;
                        8'h60, 8'h61, 8'h62, 8'h63:
                        begin
                            upd.wbyte  = v & 8'h8f;
                            upd.ev.rv  = 1'b1;
                            upd.ev.rl  = {1'b0, item.addr[1:0]};
                            upd.ev.ri  = irq_of(v & 8'h8f);
                        end
                        8'h69:       upd.wbyte = v & 8'hfa;
                        ADDR_ISA:    upd.wbyte = v & 8'h03;
                        8'h70, 8'h71:
                        begin
                            upd.wbyte  = v & 8'hcf;
                            upd.ev.rv  = 1'b1;
                            upd.ev.rl  = {2'b10, item.addr[0]};
                            upd.ev.ri  = irq_of(v & 8'hcf);
                        end
                        8'h76, 8'h77: upd.wbyte = v & 8'h8f;
                        8'ha0:        upd.wbyte = v & 8'h1f;
                        ADDR_SMI_EN:  upd.wbyte = v;
                        8'ha4:        upd.wbyte = v & 8'hf9;
                        8'ha7:        upd.wbyte = v & 8'he0;
                        ADDR_SMI_STS: upd.wbyte = old_byte | v;
                        ADDR_DMA, 8'h78, 8'h79, 8'ha5, 8'ha8, 8'hae:
                            upd.wbyte = v;
                        default:      upd.we = 1'b0;
                    endcase
                end
                else if (item.func == FUNC_IDE)
                begin
                    upd.we = 1'b1;
                    unique case (item.addr)
                        ADDR_CMD:    upd.wbyte = (v & 8'h05) | 8'h02;
                        ADDR_STATUS: upd.wbyte = old_byte & ~(v & 8'h38);
                        8'h0d:       upd.wbyte = v & 8'hf0;
                        ADDR_IDE_PRI, ADDR_IDE_SEC: upd.wbyte = v & 8'hb3;
                        ADDR_BM_LO, ADDR_BM_HI, 8'h40, 8'h42: upd.wbyte = v;
                        default:     upd.we = 1'b0;
                    endcase
                end
            end
            KIND_READ:
            begin
                if ((item.func == FUNC_BRIDGE) || (item.func == FUNC_IDE))
                begin
                    upd.ev.rd = old_byte;
                end
                else
                begin
                    upd.ev.rd = 8'hff;
                end
            end
            KIND_APM:
            begin
                // apm port sets the smi status bit when enabled
                if (smi_en)
                begin
                    upd.we     = 1'b1;
                    upd.wbyte  = old_byte | 8'h80;
                    upd.ev.smi = 1'b1;
                end
            end
            default:
            begin
                upd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pci_bridge_config_space.sv =====
`default_nettype none

// Two-function configuration space (bridge function 0, IDE function 1).
// Input channel: item is taken at a rising edge with start high and busy
// low. Each transaction is a config write, a config read or an APM control
// port write.
// Output channel: result is valid for exactly one cycle while done is high.
// The receiver cannot stall; a result is simply taken at the end of that
// cycle.
// Sequence: at accept the read of the addressed byte is registered and the
// sequencer enters ST_EXEC, where the byte is written back and done and the
// event fields are registered. busy is high in ST_EXEC, so a new transaction
// cannot be accepted before the previous write-back, because of the read
// then write-back of the single 512x8 configuration memory.
// Reset: after rst_n is released, busy stays high while the memory is
// loaded with the default image, one byte per cycle.
// Derived fields (dma alias, isa divisor, ide enables, bus master base)
// come from shadow flops kept in step with the memory writes.

module pci_bridge_config_space
    import pbcs_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire item_t   item,
    output logic         busy,
    output logic         done,
    output result_t      result
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t              state_reg;
    logic [CFG_AW-1:0]   init_cnt_reg;
    item_t               item_reg;
    event_t              ev_reg;
    logic                done_reg;
    logic                smi_en_reg;
    logic                dma_reg;
    logic                isa_reg;
    logic                ide_on_reg;
    logic                pri_reg;
    logic                sec_reg;
    logic [3:0]          bm_lo_reg;
    logic [7:0]          bm_hi_reg;

    logic                accept;
    logic [CFG_AW-1:0]   rd_addr;
    logic [CFG_AW-1:0]   item_addr;
    logic                ram_we;
    logic [CFG_AW-1:0]   ram_waddr;
    logic [7:0]          ram_wdata;
    logic [7:0]          ram_rdata;
    upd_t                upd;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // memory address of a transaction, apm port hits the smi status byte
    assign rd_addr   = (item.kind == KIND_APM) ? {1'b0, ADDR_SMI_STS}
                                               : {item.func[0], item.addr};
    assign item_addr = (item_reg.kind == KIND_APM) ? {1'b0, ADDR_SMI_STS}
                                                   : {item_reg.func[0], item_reg.addr};

    // write port: image load, then write-back
    always_comb
    begin
        if (state_reg == ST_INIT)
        begin
            ram_we    = 1'b1;
            ram_waddr = init_cnt_reg;
            ram_wdata = reset_byte(init_cnt_reg);
        end
        else
        begin
            ram_we    = (state_reg == ST_EXEC) && upd.we;
            ram_waddr = item_addr;
            ram_wdata = upd.wbyte;
        end
    end

    pbcs_ram #(
        .WIDTH (8),
        .DEPTH (CFG_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    pbcs_update u_update (
        .item     (item_reg),
        .old_byte (ram_rdata),
        .smi_en   (smi_en_reg),
        .upd      (upd)
    );

    // sequencer and registered result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_INIT:
                begin
                    init_cnt_reg <= init_cnt_reg + CFG_AW'(1);
                    if (&init_cnt_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_INIT;
                end
            endcase
        end
    end

    // transaction and event payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        if (state_reg == ST_EXEC)
        begin
            ev_reg <= upd.ev;
        end
    end

    // smi enable and shadow copies of decoded bytes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smi_en_reg <= 1'b0;
            dma_reg    <= 1'b0;
            isa_reg    <= 1'b0;
            ide_on_reg <= 1'b0;
            pri_reg    <= 1'b0;
            sec_reg    <= 1'b0;
            bm_lo_reg  <= 4'h0;
            bm_hi_reg  <= 8'h00;
        end
        else if (ram_we && (state_reg == ST_EXEC))
        begin
            if (ram_waddr == {1'b0, ADDR_SMI_EN})  smi_en_reg <= ram_wdata[7];
            if (ram_waddr == {1'b0, ADDR_DMA})     dma_reg    <= ram_wdata[7];
            if (ram_waddr == {1'b0, ADDR_ISA})     isa_reg    <= ram_wdata[0];
            if (ram_waddr == {1'b1, ADDR_CMD})     ide_on_reg <= ram_wdata[0];
            if (ram_waddr == {1'b1, ADDR_IDE_PRI}) pri_reg    <= ram_wdata[7];
            if (ram_waddr == {1'b1, ADDR_IDE_SEC}) sec_reg    <= ram_wdata[7];
            if (ram_waddr == {1'b1, ADDR_BM_LO})   bm_lo_reg  <= ram_wdata[7:4];
            if (ram_waddr == {1'b1, ADDR_BM_HI})   bm_hi_reg  <= ram_wdata;
        end
    end

    // result assembly
    assign done                    = done_reg;
    assign result.read_data        = ev_reg.rd;
    assign result.smi_pulse        = ev_reg.smi;
    assign result.route_valid      = ev_reg.rv;
    assign result.route_line       = ev_reg.rl;
    assign result.route_irq        = ev_reg.ri;
    assign result.dma_alias_on     = dma_reg;
    assign result.isa_divisor      = 3'd3 + {2'b00, isa_reg};
    assign result.ide_primary_on   = ide_on_reg && pri_reg;
    assign result.ide_secondary_on = ide_on_reg && sec_reg;
    assign result.bus_master_on    = ide_on_reg;
    assign result.bus_master_base  = {bm_hi_reg, bm_lo_reg, 4'h0};

    // checks
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("result strobe without a write-back cycle");

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 done)
        else $error("accepted transaction gave no result");

    a_no_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("memory written while idle");

    a_smi_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && upd.ev.smi) |-> smi_en_reg)
        else $error("smi raised while disabled");

endmodule

`default_nettype wire

// ===== sim/pci_bridge_config_space_tb.sv =====
`timescale 1ns / 1ps

module pci_bridge_config_space_tb
    import pbcs_pkg::*;
();

    // header and id offsets
    localparam logic [7:0] ADDR_VENDOR_LO = 8'h00;
    localparam logic [7:0] ADDR_VENDOR_HI = 8'h01;
    localparam logic [7:0] ADDR_DEVICE_LO = 8'h02;
    localparam logic [7:0] ADDR_DEVICE_HI = 8'h03;
    localparam logic [7:0] ADDR_STAT_LO   = 8'h06;
    localparam logic [7:0] ADDR_REV       = 8'h08;
    localparam logic [7:0] ADDR_PROG_IF   = 8'h09;
    localparam logic [7:0] ADDR_SUBCLASS  = 8'h0a;
    localparam logic [7:0] ADDR_CLASS     = 8'h0b;
    localparam logic [7:0] ADDR_LATENCY   = 8'h0d;
    localparam logic [7:0] ADDR_HDR_TYPE  = 8'h0e;
    localparam logic [7:0] ADDR_UNLISTED  = 8'h05;
    localparam logic [7:0] ADDR_TOP       = 8'hff;

    // bridge function registers
    localparam logic [7:0] ADDR_ISA_CTL = 8'h4e;
    localparam logic [7:0] ADDR_PIRQ_A  = 8'h60;
    localparam logic [7:0] ADDR_PIRQ_B  = 8'h61;
    localparam logic [7:0] ADDR_PIRQ_C  = 8'h62;
    localparam logic [7:0] ADDR_PIRQ_D  = 8'h63;
    localparam logic [7:0] ADDR_TOP_MEM = 8'h69;
    localparam logic [7:0] ADDR_MIRQ0   = 8'h70;
    localparam logic [7:0] ADDR_MIRQ1   = 8'h71;
    localparam logic [7:0] ADDR_MBDMA0  = 8'h76;
    localparam logic [7:0] ADDR_MBDMA1  = 8'h77;
    localparam logic [7:0] ADDR_PCSC_LO = 8'h78;
    localparam logic [7:0] ADDR_PCSC_HI = 8'h79;
    localparam logic [7:0] ADDR_SMI_CTL = 8'ha0;
    localparam logic [7:0] ADDR_SEE_LO  = 8'ha4;
    localparam logic [7:0] ADDR_SEE_MID = 8'ha5;
    localparam logic [7:0] ADDR_SEE_HI  = 8'ha7;
    localparam logic [7:0] ADDR_FTMR    = 8'ha8;
    localparam logic [7:0] ADDR_CTLTMR  = 8'hae;

    // ide function registers
    localparam logic [7:0] ADDR_IDE_PRI_LO = 8'h40;
    localparam logic [7:0] ADDR_IDE_SEC_LO = 8'h42;

    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam logic [2:0] FUNC_ABSENT  = 3'd7;
    localparam int         RANDOM_ITEMS = 1325;
    localparam int         IDLE_LIMIT   = 3000;

    typedef struct {
        item_t acc;
        bit    drain;
    } access_t;

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    // predictor state
    logic [7:0] bridge_cfg [0:255];
    logic [7:0] ide_cfg [0:255];
    logic       apm_smi_on;

    access_t access_q [$];
    result_t outcome_q [$];
    int      gap_left = 0;
    int      burst_left = 0;
    int      mismatches = 0;
    int      idle_cycles = 0;

    pci_bridge_config_space dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // power-on contents of both functions
    task automatic load_power_on_image();
        for (int i = 0; i < 256; i++)
        begin
            bridge_cfg[i] = 8'h00;
            ide_cfg[i] = 8'h00;
        end
        bridge_cfg[ADDR_VENDOR_LO] = 8'h86;
        bridge_cfg[ADDR_VENDOR_HI] = 8'h80;
        bridge_cfg[ADDR_DEVICE_LO] = 8'h2e;
        bridge_cfg[ADDR_DEVICE_HI] = 8'h12;
        bridge_cfg[ADDR_CMD]       = 8'h07;
        bridge_cfg[ADDR_STATUS]    = 8'h02;
        bridge_cfg[ADDR_REV]       = 8'h02;
        bridge_cfg[ADDR_SUBCLASS]  = 8'h01;
        bridge_cfg[ADDR_CLASS]     = 8'h06;
        bridge_cfg[ADDR_HDR_TYPE]  = 8'h80;
        bridge_cfg[ADDR_DMA]       = 8'h4d;
        bridge_cfg[ADDR_ISA_CTL]   = 8'h03;
        bridge_cfg[ADDR_PIRQ_A]    = 8'h80;
        bridge_cfg[ADDR_PIRQ_B]    = 8'h80;
        bridge_cfg[ADDR_PIRQ_C]    = 8'h80;
        bridge_cfg[ADDR_PIRQ_D]    = 8'h80;
        bridge_cfg[ADDR_TOP_MEM]   = 8'h02;
        bridge_cfg[ADDR_MIRQ0]     = 8'h80;
        bridge_cfg[ADDR_MIRQ1]     = 8'h80;
        bridge_cfg[ADDR_MBDMA0]    = 8'h0c;
        bridge_cfg[ADDR_MBDMA1]    = 8'h0c;
        bridge_cfg[ADDR_SMI_CTL]   = 8'h08;
        bridge_cfg[ADDR_FTMR]      = 8'h0f;
        ide_cfg[ADDR_VENDOR_LO]    = 8'h86;
        ide_cfg[ADDR_VENDOR_HI]    = 8'h80;
        ide_cfg[ADDR_DEVICE_LO]    = 8'h30;
        ide_cfg[ADDR_DEVICE_HI]    = 8'h12;
        ide_cfg[ADDR_STAT_LO]      = 8'h80;
        ide_cfg[ADDR_STATUS]       = 8'h02;
        ide_cfg[ADDR_REV]          = 8'h02;
        ide_cfg[ADDR_PROG_IF]      = 8'h80;
        ide_cfg[ADDR_SUBCLASS]     = 8'h01;
        ide_cfg[ADDR_CLASS]        = 8'h01;
        ide_cfg[ADDR_BM_LO]        = 8'h01;
        apm_smi_on = 1'b0;
    endtask

    // irq a routing byte points at, 0 when disabled or not routable
    function automatic logic [3:0] route_target(input logic [7:0] b);
        if (!b[7])
            return 4'd0;
        case (b[3:0])
            4'd0, 4'd1, 4'd2, 4'd8, 4'd13: return 4'd0;
            default: return b[3:0];
        endcase
    endfunction

    // apply one transaction to the shadow space and form its result
    function automatic result_t cfg_access_outcome(input item_t acc);
        result_t    res;
        logic [7:0] v;
        logic       ide_on;
        res = '0;
        v = acc.data;
        if (acc.kind == KIND_WRITE && acc.func == FUNC_BRIDGE)
        begin
            case (acc.addr)
                ADDR_CMD:     bridge_cfg[acc.addr] = (v & 8'h08) | 8'h07;
                ADDR_STATUS:  bridge_cfg[acc.addr] = bridge_cfg[acc.addr] & ~(v & 8'h38);
                ADDR_ISA_CTL: bridge_cfg[acc.addr] = v & 8'hf7;
                ADDR_PIRQ_A, ADDR_PIRQ_B, ADDR_PIRQ_C, ADDR_PIRQ_D:
                begin
                    // lines 0-3 follow the low two offset bits
                    bridge_cfg[acc.addr] = v & 8'h8f;
                    res.route_valid = 1'b1;
                    res.route_line = {1'b0, acc.addr[1:0]};
                    res.route_irq = route_target(bridge_cfg[acc.addr]);
                end
                ADDR_TOP_MEM: bridge_cfg[acc.addr] = v & 8'hfa;
                ADDR_ISA:     bridge_cfg[acc.addr] = v & 8'h03;
                ADDR_MIRQ0, ADDR_MIRQ1:
                begin
                    // motherboard lines sit at 4 and 5
                    bridge_cfg[acc.addr] = v & 8'hcf;
                    res.route_valid = 1'b1;
                    res.route_line = {2'b10, acc.addr[0]};
                    res.route_irq = route_target(bridge_cfg[acc.addr]);
                end
                ADDR_MBDMA0, ADDR_MBDMA1: bridge_cfg[acc.addr] = v & 8'h8f;
                ADDR_SMI_CTL: bridge_cfg[acc.addr] = v & 8'h1f;
                ADDR_SMI_EN:
                begin
                    bridge_cfg[acc.addr] = v;
                    apm_smi_on = v[7];
                end
                ADDR_SEE_LO:  bridge_cfg[acc.addr] = v & 8'hf9;
                ADDR_SEE_HI:  bridge_cfg[acc.addr] = v & 8'he0;
                ADDR_SMI_STS: bridge_cfg[acc.addr] = bridge_cfg[acc.addr] | v;
                ADDR_DMA, ADDR_PCSC_LO, ADDR_PCSC_HI, ADDR_SEE_MID, ADDR_FTMR, ADDR_CTLTMR:
                    bridge_cfg[acc.addr] = v;
                default: ;
            endcase
        end
        else if (acc.kind == KIND_WRITE && acc.func == FUNC_IDE)
        begin
            case (acc.addr)
                ADDR_CMD:     ide_cfg[acc.addr] = (v & 8'h05) | 8'h02;
                ADDR_STATUS:  ide_cfg[acc.addr] = ide_cfg[acc.addr] & ~(v & 8'h38);
                ADDR_LATENCY: ide_cfg[acc.addr] = v & 8'hf0;
                ADDR_IDE_PRI, ADDR_IDE_SEC: ide_cfg[acc.addr] = v & 8'hb3;
                ADDR_BM_LO, ADDR_BM_HI, ADDR_IDE_PRI_LO, ADDR_IDE_SEC_LO:
                    ide_cfg[acc.addr] = v;
                default: ;
            endcase
        end
        else if (acc.kind == KIND_READ)
        begin
            if (acc.func == FUNC_BRIDGE)
                res.read_data = bridge_cfg[acc.addr];
            else if (acc.func == FUNC_IDE)
                res.read_data = ide_cfg[acc.addr];
            else
                res.read_data = 8'hff;
        end
        else if (acc.kind == KIND_APM && apm_smi_on)
        begin
            res.smi_pulse = 1'b1;
            bridge_cfg[ADDR_SMI_STS] = bridge_cfg[ADDR_SMI_STS] | 8'h80;
        end

        // decoded fields from the space as it stands now
        ide_on = ide_cfg[ADDR_CMD][0];
        res.dma_alias_on     = bridge_cfg[ADDR_DMA][7];
        res.isa_divisor      = bridge_cfg[ADDR_ISA][0] ? 3'd4 : 3'd3;
        res.ide_primary_on   = ide_on & ide_cfg[ADDR_IDE_PRI][7];
        res.ide_secondary_on = ide_on & ide_cfg[ADDR_IDE_SEC][7];
        res.bus_master_on    = ide_on;
        res.bus_master_base  = {ide_cfg[ADDR_BM_HI], ide_cfg[ADDR_BM_LO][7:4], 4'h0};
        return res;
    endfunction

    // writable offsets of each function
    function automatic logic [7:0] listed_offset(input bit ide_side, input int n);
        if (ide_side)
        begin
            case (n)
                0: return ADDR_CMD;
                1: return ADDR_STATUS;
                2: return ADDR_LATENCY;
                3: return ADDR_BM_LO;
                4: return ADDR_BM_HI;
                5: return ADDR_IDE_PRI_LO;
                6: return ADDR_IDE_PRI;
                7: return ADDR_IDE_SEC_LO;
                default: return ADDR_IDE_SEC;
            endcase
        end
        case (n)
            0: return ADDR_CMD;
            1: return ADDR_STATUS;
            2: return ADDR_DMA;
            3: return ADDR_ISA_CTL;
            4: return ADDR_PIRQ_A;
            5: return ADDR_PIRQ_B;
            6: return ADDR_PIRQ_C;
            7: return ADDR_PIRQ_D;
            8: return ADDR_TOP_MEM;
            9: return ADDR_ISA;
            10: return ADDR_MIRQ0;
            11: return ADDR_MIRQ1;
            12: return ADDR_MBDMA0;
            13: return ADDR_MBDMA1;
            14: return ADDR_PCSC_LO;
            15: return ADDR_PCSC_HI;
            16: return ADDR_SMI_CTL;
            17: return ADDR_SMI_EN;
            18: return ADDR_SEE_LO;
            19: return ADDR_SEE_MID;
            20: return ADDR_SEE_HI;
            21: return ADDR_FTMR;
            22: return ADDR_SMI_STS;
            default: return ADDR_CTLTMR;
        endcase
    endfunction

    task automatic queue_access(input logic [1:0] kind, input logic [2:0] func,
                                input logic [7:0] addr, input logic [7:0] data,
                                input bit drain = 1'b0);
        access_t a;
        a.acc.kind = kind;
        a.acc.func = func;
        a.acc.addr = addr;
        a.acc.data = data;
        a.drain = drain;
        access_q.push_back(a);
    endtask

    // idle time after a transaction: mostly none or short, a few long, some bursts
    function automatic int next_gap();
        int r;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // driver: present the next access once the previous one is taken
    always @(posedge clk)
    begin : driver
        logic fire;
        fire = start && !busy;
        if (rst_n)
        begin
            if (fire)
                outcome_q.push_back(cfg_access_outcome(item));
            if (!start || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (access_q.size() != 0
                         && !(access_q[0].drain && outcome_q.size() != 0))
                begin
                    item <= access_q[0].acc;
                    start <= 1'b1;
                    void'(access_q.pop_front());
                    gap_left = next_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor: every strobed result against the oldest prediction
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, result);
                mismatches++;
            end
            else
            begin
                want = outcome_q.pop_front();
                compare_field("read_data", 16'(want.read_data), 16'(result.read_data));
                compare_field("smi_pulse", 16'(want.smi_pulse), 16'(result.smi_pulse));
                compare_field("route_valid", 16'(want.route_valid),
                              16'(result.route_valid));
                compare_field("route_line", 16'(want.route_line), 16'(result.route_line));
                compare_field("route_irq", 16'(want.route_irq), 16'(result.route_irq));
                compare_field("dma_alias_on", 16'(want.dma_alias_on),
                              16'(result.dma_alias_on));
                compare_field("isa_divisor", 16'(want.isa_divisor),
                              16'(result.isa_divisor));
                compare_field("ide_primary_on", 16'(want.ide_primary_on),
                              16'(result.ide_primary_on));
                compare_field("ide_secondary_on", 16'(want.ide_secondary_on),
                              16'(result.ide_secondary_on));
                compare_field("bus_master_on", 16'(want.bus_master_on),
                              16'(result.bus_master_on));
                compare_field("bus_master_base", want.bus_master_base,
                              result.bus_master_base);
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int  useful;
        int  r;
        bit  ide_side;
        logic [2:0] f;
        load_power_on_image();

        // directed: ids, absent functions, routing corners, smi, w1c, derived fields
        queue_access(KIND_READ, FUNC_BRIDGE, ADDR_VENDOR_LO, 8'h00);
        queue_access(KIND_READ, FUNC_IDE, ADDR_DEVICE_LO, 8'hff);
        queue_access(KIND_READ, FUNC_ABSENT, ADDR_TOP, 8'h00);
        queue_access(KIND_WRITE, FUNC_ABSENT, ADDR_DMA, 8'hff);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_UNLISTED, 8'hff);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_CMD, 8'hff);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_PIRQ_A, 8'h8b);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_PIRQ_B, 8'h88);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_PIRQ_C, 8'h0b);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_PIRQ_D, 8'hff);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_MIRQ0, 8'hff);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_MIRQ1, 8'h00);
        queue_access(KIND_APM, FUNC_BRIDGE, ADDR_TOP, 8'hff);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_SMI_EN, 8'h80);
        queue_access(KIND_APM, FUNC_ABSENT, 8'h00, 8'h00);
        queue_access(KIND_READ, FUNC_BRIDGE, ADDR_SMI_STS, 8'h00);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_SMI_STS, 8'h01);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_DMA, 8'h80);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_ISA, 8'hff);
        queue_access(KIND_WRITE, FUNC_IDE, ADDR_CMD, 8'hff);
        queue_access(KIND_WRITE, FUNC_IDE, ADDR_IDE_PRI, 8'hff);
        queue_access(KIND_WRITE, FUNC_IDE, ADDR_IDE_SEC, 8'h80);
        queue_access(KIND_WRITE, FUNC_IDE, ADDR_BM_LO, 8'hff);
        queue_access(KIND_WRITE, FUNC_IDE, ADDR_BM_HI, 8'hff);
        queue_access(KIND_WRITE, FUNC_IDE, ADDR_STATUS, 8'hff);
        queue_access(KIND_UNUSED, FUNC_ABSENT, ADDR_TOP, 8'hff);
        queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_SMI_EN, 8'h00, 1'b1);

        // random: mostly listed writes and reads, some port writes and noise
        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            ide_side = ($urandom_range(0, 2) == 0);
            f = ide_side ? FUNC_IDE : FUNC_BRIDGE;
            if (r < 35)
            begin
                queue_access(KIND_WRITE, f, listed_offset(ide_side, $urandom_range(0, 23)),
                             8'($urandom_range(0, 255)), (useful % 300) == 299);
                useful++;
            end
            else if (r < 65)
            begin
                if ($urandom_range(0, 9) == 0)
                    f = 3'($urandom_range(2, 7));
                queue_access(KIND_READ, f,
                             $urandom_range(0, 1) ? listed_offset(ide_side, $urandom_range(0, 23))
                                                  : 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                useful++;
            end
            else if (r < 75)
            begin
                queue_access(KIND_APM, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255)));
                useful++;
            end
            else if (r < 82)
            begin
                // rewrite apm smi enable with a random byte
                queue_access(KIND_WRITE, FUNC_BRIDGE, ADDR_SMI_EN,
                             8'($urandom_range(0, 255)));
                useful++;
            end
            else
            begin
                queue_access(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                useful++;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (access_q.size() != 0 || start || outcome_q.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
